### hw/rtl/s64x_pkg.sv
// Shared types, constants and the symbol decode table for the scanner decoder.
`timescale 1ns / 1ps
`default_nettype none

package s64x_pkg;

  localparam logic [7:0] DOT_CODE    = 8'd46;
  localparam logic [1:0] DOTS_NEEDED = 2'd3;
  localparam logic [7:0] KEY_RESET   = 8'd67;
  localparam int         JOB_DEPTH   = 4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FEW_DOTS = 2'd1;
  localparam logic [1:0] ST_BAD_CHAR = 2'd2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_final;
  } in_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       has_byte;
    logic       end_of_message;
    logic [1:0] status;
  } out_t;

  // One unit of work for the back end: up to three bytes, already keyed.
  typedef struct packed {
    logic [23:0] data;
    logic [1:0]  last_idx;
    logic        has_byte;
    logic        eom;
    logic [1:0]  status;
  } job_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sym_t;

  // Alphabet: a..z, A..Z, 0..9, '+', '-'.
  function automatic sym_t sym_decode(input logic [7:0] code);
    sym_t s;
    s.ok  = 1'b1;
    s.val = 6'd0;
    if (code >= 8'd97 && code <= 8'd122) begin
      s.val = 6'(code - 8'd97);
    end else if (code >= 8'd65 && code <= 8'd90) begin
      s.val = 6'(code - 8'd65 + 8'd26);
    end else if (code >= 8'd48 && code <= 8'd57) begin
      s.val = 6'(code - 8'd48 + 8'd52);
    end else if (code == 8'd43) begin
      s.val = 6'd62;
    end else if (code == 8'd45) begin
      s.val = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/scanner_base64_xor_decoder.sv
// Top level of the scanner token decoder.
//
// Takes one scanner character per cycle while in_full is low. Characters up
// to and including the third dot are skipped; later ones are decoded through
// the 64-symbol alphabet, four symbols give three bytes XORed with the key.
// The final character yields the flush bytes (or one result without a byte)
// and ends the token. The front end pushes any job for a character in the same
// cycle as it takes the character; results leave the output register one
// per cycle while out_pop is high, so one character per cycle is sustained
// (four symbols produce three bytes). The first result of a character
// passes through the job queue and then the output register before it shows.
// A job queue of JOB_DEPTH entries absorbs output stalls; in_full rises when
// it fills. Write the key through cfg_we only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module scanner_base64_xor_decoder #(
  parameter int JOB_DEPTH = s64x_pkg::JOB_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire s64x_pkg::in_t in_data,
  output logic               out_empty,
  input  wire logic          out_pop,
  output s64x_pkg::out_t     out_data,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_data
);

  logic            job_push, job_full, job_valid, job_pop;
  s64x_pkg::job_t  job_in, job_head;

  assign in_full = job_full;

  s64x_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .job_full (job_full),
    .job_push (job_push),
    .job      (job_in)
  );

  s64x_jobq #(
    .DEPTH (JOB_DEPTH)
  ) u_jobq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_data  (job_in),
    .full       (job_full),
    .head_valid (job_valid),
    .head       (job_head),
    .pop        (job_pop)
  );

  s64x_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job_head),
    .job_pop   (job_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### hw/rtl/s64x_front.sv
// Front end: header skip, symbol decode, group packing and job building.
`timescale 1ns / 1ps
`default_nettype none

module s64x_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  input  wire s64x_pkg::in_t in_data,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_data,
  input  wire logic          job_full,
  output logic               job_push,
  output s64x_pkg::job_t     job
);

  logic [7:0]  key_r;
  logic [1:0]  dots_r, dots_nxt;
  logic [1:0]  grp_cnt_r, grp_cnt_nxt;
  logic [17:0] grp_bits_r, grp_bits_nxt;
  logic [1:0]  err_r, err_nxt;

  logic            accept;
  logic            hdr_done;
  s64x_pkg::sym_t  sym;
  logic [23:0]     padded;
  logic [23:0]     key3;

  assign accept   = in_push && !job_full;
  assign hdr_done = (dots_r == s64x_pkg::DOTS_NEEDED);
  assign sym      = s64x_pkg::sym_decode(in_data.char_code);
  assign key3     = {key_r, key_r, key_r};
  // Pad a partial group with zero symbols up to a full 24-bit word.
  assign padded   = (grp_cnt_r == 2'd2) ? {grp_bits_r[11:0], 12'd0}
                                        : {grp_bits_r, 6'd0};

  always_comb begin
    dots_nxt     = dots_r;
    grp_cnt_nxt  = grp_cnt_r;
    grp_bits_nxt = grp_bits_r;
    err_nxt      = err_r;
    job_push     = 1'b0;
    job          = '0;
    if (accept) begin
      if (in_data.is_final) begin
        job_push = 1'b1;
        job.eom  = 1'b1;
        if (!hdr_done) begin
          job.status = s64x_pkg::ST_FEW_DOTS;
        end else begin
          job.status = err_r;
          if (grp_cnt_r >= 2'd2) begin
            job.has_byte = 1'b1;
            job.data     = padded ^ key3;
            job.last_idx = grp_cnt_r - 2'd2;
          end
        end
        dots_nxt     = '0;
        grp_cnt_nxt  = '0;
        grp_bits_nxt = '0;
        err_nxt      = s64x_pkg::ST_OK;
      end else if (!hdr_done) begin
        if (in_data.char_code == s64x_pkg::DOT_CODE) begin
          dots_nxt = dots_r + 2'd1;
        end
      end else if (!sym.ok) begin
        err_nxt = s64x_pkg::ST_BAD_CHAR;
      end else if (grp_cnt_r != 2'd3) begin
        grp_bits_nxt = {grp_bits_r[11:0], sym.val};
        grp_cnt_nxt  = grp_cnt_r + 2'd1;
      end else begin
        job_push     = 1'b1;
        job.data     = {grp_bits_r, sym.val} ^ key3;
        job.last_idx = 2'd2;
        job.has_byte = 1'b1;
        job.status   = err_r;
        grp_cnt_nxt  = '0;
        grp_bits_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r      <= s64x_pkg::KEY_RESET;
      dots_r     <= '0;
      grp_cnt_r  <= '0;
      grp_bits_r <= '0;
      err_r      <= s64x_pkg::ST_OK;
    end else begin
      if (cfg_we) begin
        key_r <= cfg_data;
      end
      dots_r     <= dots_nxt;
      grp_cnt_r  <= grp_cnt_nxt;
      grp_bits_r <= grp_bits_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/s64x_jobq.sv
// Small job queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module s64x_jobq #(
  parameter int DEPTH = s64x_pkg::JOB_DEPTH  // at least 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire s64x_pkg::job_t push_data,
  output logic                full,
  output logic                head_valid,
  output s64x_pkg::job_t      head,
  input  wire logic           pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  s64x_pkg::job_t   slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/s64x_back.sv
// Back end: unrolls each job into result transfers through an output register.
`timescale 1ns / 1ps
`default_nettype none

module s64x_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_valid,
  input  wire s64x_pkg::job_t job,
  output logic                job_pop,
  output logic                out_empty,
  input  wire logic           out_pop,
  output s64x_pkg::out_t      out_data
);

  logic [1:0]      idx_r;
  logic            out_valid_r;
  s64x_pkg::out_t  out_r;
  s64x_pkg::out_t  res;
  logic            load;
  logic            last;

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign load      = job_valid && (!out_valid_r || out_pop);
  assign last      = (idx_r == job.last_idx);
  assign job_pop   = load && last;

  always_comb begin
    res = '0;
    unique case (idx_r)
      2'd0:    res.byte_value = job.data[23:16];
      2'd1:    res.byte_value = job.data[15:8];
      default: res.byte_value = job.data[7:0];
    endcase
    res.has_byte       = job.has_byte;
    res.end_of_message = job.eom && last;
    res.status         = job.status;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        // advance through the job's bytes, rewind on its last one
        idx_r <= last ? 2'd0 : idx_r + 2'd1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/s64x_checker.sv
// Port-level checker for the scanner decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module s64x_port_checks (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           out_empty,
  input  wire logic           out_pop,
  input  wire s64x_pkg::out_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("stalled result changed or vanished");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result shown right after reset");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.has_byte) |->
      (out_data.byte_value == 8'd0 && out_data.end_of_message))
    else $error("result without byte is not a clean end of token");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.status == s64x_pkg::ST_FEW_DOTS) |->
      (!out_data.has_byte && out_data.end_of_message))
    else $error("short header status on a byte result");

endmodule

bind scanner_base64_xor_decoder s64x_port_checks u_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

`default_nettype wire
